/* hw/rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// String table sorter package
// Operation codes and item field widths shared by the sorter and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int OpW    = 2;
  localparam int IdxW   = 5;
  localparam int PosW   = 6;
  localparam int CharW  = 8;
  localparam int CntW   = 6;

  // Input tdata: index, position, value and count packed, padded to bytes.
  localparam int STdataW = 32;
  localparam int MTdataW = CharW;

  localparam logic [OpW-1:0] OP_WRITE = 2'd0;
  localparam logic [OpW-1:0] OP_SORT  = 2'd1;
  localparam logic [OpW-1:0] OP_READ  = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/string_table_sorter.sv */
// ----------------------------------------------------------------------------
// String table sorter
// Byte-addressed table of strings with an in-place bubble sort. Strings are
// reached through a slot map, so a swap exchanges two map entries instead of
// moving whole strings. One shared byte comparator walks each compared pair.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tdata (low bit first)                   | tuser
//  s_axis   | in        | string_index, char_position, char_value, | operation
//           |           | string_count, zero pad to 32 bits        |
//  m_axis   | out       | read_char                                | status
//
//  A write or read item goes through S_ACC and then S_RESP to its result.
//  A sort of n strings does n*(n-1)/2 compares. Each reads the map pair in
//  S_MAP, then compares one byte pair per S_BRD/S_BCMP step on the byte
//  comparator; a swap writes the map in S_SW1 then S_SW2 on the single map write port.
//  No item is accepted while one is in work; a finished result waits in the
//  output register while the next item is taken.
//  Reset clears the slot map to identity at once; the byte store is not
//  cleared and needs no start-up pass.
// ----------------------------------------------------------------------------
`default_nettype none

module string_table_sorter
  import sts_pkg::*;
#(
  parameter int NUM_STRINGS  = 32,
  parameter int STRING_BYTES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // [4:0] string_index, [10:5] char_position, [18:11] char_value,
  // [24:19] string_count, [31:25] zero
  input  wire logic [STdataW-1:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [OpW-1:0]     s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [7:0] read_char
  output logic [MTdataW-1:0]      m_axis_tdata,
  // [0] status
  output logic                    m_axis_tuser
);

  localparam int SW    = (NUM_STRINGS > 2) ? $clog2(NUM_STRINGS) : 1;
  localparam int PW    = (STRING_BYTES > 2) ? $clog2(STRING_BYTES) : 1;
  localparam int Depth = NUM_STRINGS * STRING_BYTES;
  localparam int AW    = $clog2(Depth);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_RESP = 4'd2;
  localparam logic [3:0] S_MAP  = 4'd3;
  localparam logic [3:0] S_BRD  = 4'd4;
  localparam logic [3:0] S_BCMP = 4'd5;
  localparam logic [3:0] S_SW1  = 4'd6;
  localparam logic [3:0] S_SW2  = 4'd7;

  // Input item fields
  logic [IdxW-1:0]  in_slot;
  logic [PosW-1:0]  in_pos;
  logic [CharW-1:0] in_val;
  logic [CntW-1:0]  in_cnt;
  logic             in_ok;
  logic             accept;

  assign in_slot = s_axis_tdata[IdxW-1:0];
  assign in_pos  = s_axis_tdata[IdxW +: PosW];
  assign in_val  = s_axis_tdata[IdxW+PosW +: CharW];
  assign in_cnt  = s_axis_tdata[IdxW+PosW+CharW +: CntW];
  assign in_ok   = (32'(in_slot) < NUM_STRINGS) && (32'(in_pos) < STRING_BYTES);

  // Control state
  logic [3:0]        state_q, state_d;
  logic [SW-1:0]     j_q, j_d;
  logic [SW-1:0]     lim_q, lim_d;
  logic [PW-1:0]     k_q, k_d;
  logic              stat_q, stat_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              out_stat_q, out_stat_d;

  // Item payload
  logic [OpW-1:0]    op_q;
  logic              ok_q;
  logic [PW-1:0]     pos_q;
  logic [CharW-1:0]  val_q;

  // Slot map: logical slot to physical row, identity until first written
  logic [SW-1:0]     map_mem [NUM_STRINGS];
  logic [NUM_STRINGS-1:0] map_vld_q;
  logic [SW-1:0]     map_ra, map_rb, map_wa, map_wd;
  logic              map_re, map_we;
  logic [SW-1:0]     map_a_q, map_b_q, idx_a_q, idx_b_q;
  logic              vld_a_q, vld_b_q;
  logic [SW-1:0]     phys_a, phys_b;

  // Byte store
  logic [CharW-1:0]  store_mem [Depth];
  logic [AW-1:0]     addr_a, addr_b;
  logic [PW-1:0]     byte_a;
  logic              store_we, store_re;
  logic [CharW-1:0]  rd_a_q, rd_b_q;

  logic              out_free;
  logic [SW-1:0]     j_next;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign j_next        = j_q + SW'(1);

  assign map_ra = (state_q == S_IDLE) ? SW'(in_slot) : j_q;
  assign map_rb = j_next;
  assign map_re = accept || (state_q == S_MAP);
  assign map_we = (state_q == S_SW1) || (state_q == S_SW2);
  assign map_wa = (state_q == S_SW1) ? j_q : j_next;
  assign map_wd = (state_q == S_SW1) ? phys_b : phys_a;

  assign phys_a = vld_a_q ? map_a_q : idx_a_q;
  assign phys_b = vld_b_q ? map_b_q : idx_b_q;

  assign byte_a   = (state_q == S_ACC) ? pos_q : k_q;
  assign addr_a   = AW'(phys_a) * AW'(STRING_BYTES) + AW'(byte_a);
  assign addr_b   = AW'(phys_b) * AW'(STRING_BYTES) + AW'(k_q);
  assign store_we = (state_q == S_ACC) && (op_q == OP_WRITE) && ok_q;
  assign store_re = ((state_q == S_ACC) && (op_q == OP_READ)) || (state_q == S_BRD);

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_a_q <= map_mem[map_ra];
      map_b_q <= map_mem[map_rb];
      vld_a_q <= map_vld_q[map_ra];
      vld_b_q <= map_vld_q[map_rb];
      idx_a_q <= map_ra;
      idx_b_q <= map_rb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q <= '0;
    end else if (map_we) begin
      map_vld_q[map_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[addr_a] <= val_q;
    end
    if (store_re) begin
      rd_a_q <= store_mem[addr_a];
      rd_b_q <= store_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tuser;
      ok_q  <= in_ok;
      pos_q <= PW'(in_pos);
      val_q <= in_val;
    end
  end

  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    lim_d       = lim_q;
    k_d         = k_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_stat_d  = out_stat_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          stat_d = 1'b0;
          j_d    = '0;
          if (s_axis_tuser == OP_SORT) begin
            if (32'(in_cnt) > NUM_STRINGS) begin
              stat_d  = 1'b1;
              state_d = S_RESP;
            end else if (in_cnt < CntW'(2)) begin
              state_d = S_RESP;
            end else begin
              lim_d   = SW'(in_cnt - CntW'(1));
              state_d = S_MAP;
            end
          end else if (s_axis_tuser == OP_WRITE || s_axis_tuser == OP_READ) begin
            state_d = S_ACC;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_ACC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = (op_q == OP_READ && ok_q) ? rd_a_q : '0;
          out_stat_d  = stat_q;
          state_d     = S_IDLE;
        end
      end
      S_MAP: begin
        k_d     = '0;
        state_d = S_BRD;
      end
      S_BRD: begin
        state_d = S_BCMP;
      end
      S_BCMP: begin
        if (rd_a_q != rd_b_q) begin
          state_d = (rd_a_q > rd_b_q) ? S_SW1 : S_IDLE;
        end else if (rd_a_q == '0 || k_q == PW'(STRING_BYTES - 1)) begin
          state_d = S_IDLE;
        end else begin
          k_d     = k_q + PW'(1);
          state_d = S_BRD;
        end
      end
      S_SW1: begin
        state_d = S_SW2;
      end
      S_SW2: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The pair is settled (kept or swapped): move to the next pair or pass.
    if ((state_q == S_BCMP && state_d == S_IDLE) || state_q == S_SW2) begin
      if (j_next == lim_q) begin
        if (lim_q == SW'(1)) begin
          state_d = S_RESP;
        end else begin
          lim_d   = lim_q - SW'(1);
          j_d     = '0;
          state_d = S_MAP;
        end
      end else begin
        j_d     = j_next;
        state_d = S_MAP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      j_q         <= '0;
      lim_q       <= '0;
      k_q         <= '0;
      stat_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_stat_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      lim_q       <= lim_d;
      k_q         <= k_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_stat_q  <= out_stat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

`default_nettype wire

/* hw/rtl/sts_checker.sv */
// ----------------------------------------------------------------------------
// String table sorter checker
// Port-level assertions on item flow and result contents, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_checker
  import sts_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic [STdataW-1:0] s_axis_tdata,
  input wire logic [OpW-1:0]     s_axis_tuser,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [MTdataW-1:0] m_axis_tdata,
  input wire logic               m_axis_tuser
);

  logic [OpW-1:0] last_op_q;

  // Operation of the most recently accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_op_q <= OP_WRITE;
    end else if (s_axis_tvalid && s_axis_tready) begin
      last_op_q <= s_axis_tuser;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again before the item was done");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an item in work");

  a_status_from_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && m_axis_tuser |-> last_op_q == OP_SORT && m_axis_tdata == '0)
    else $error("refused status on an item that was not a sort");

  a_char_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && m_axis_tdata != '0 |-> last_op_q == OP_READ)
    else $error("nonzero byte on an item that was not a read");

endmodule

bind string_table_sorter sts_checker u_sts_checker (.*);

`default_nettype wire
